>>> hdl/nrp_pkg.sv
package nrp_pkg;

    // Line and number limits
    localparam int LINE_LIMIT             = 127;
    localparam int MINUTE_FRACTION_DIGITS = 5;

    localparam int LEN_W     = $clog2(LINE_LIMIT + 1);
    localparam int WHOLE_W   = 17;
    localparam int WHOLE_MAX = 131071;
    localparam int FRAC_W    = $clog2(10 ** MINUTE_FRACTION_DIGITS);
    localparam int DIG_W     = 3;
    localparam int FIELD_W   = 3;
    localparam int FIELD_MAX = 7;

    // Field positions within an RMC sentence
    localparam logic [FIELD_W-1:0] FLD_STATUS = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_LAT    = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_NS     = 3'd4;
    localparam logic [FIELD_W-1:0] FLD_LON    = 3'd5;
    localparam logic [FIELD_W-1:0] FLD_EW     = 3'd6;

    // Conversion datapath widths
    localparam int MIN_W   = $clog2(100 * (10 ** MINUTE_FRACTION_DIGITS));
    localparam int SC_W    = 30;
    localparam int Y_W     = SC_W - 2;
    localparam int Q_W     = 25;
    localparam int DEG_W   = 31;
    localparam int COORD_W = 32;
    localparam int W15_W   = 15;

    localparam logic [23:0]        E7          = 24'd10000000;
    localparam logic [COORD_W-1:0] COORD_MAX   = 32'd1800000000;
    localparam logic [WHOLE_W-1:0] SAT_WHOLE   = 17'd18000;
    localparam logic [12:0]        DIV100_MUL  = 13'd5243;
    localparam int                 DIV100_SHR  = 19;
    localparam logic [28:0]        RECIP15     = 29'd286331153;

    // Request queue between scanner and converter
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Converter pipeline depth (register stages inside one lane)
    localparam int CONV_STAGES = 6;

    // Characters
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_W      = 8'h57;

    typedef enum logic [1:0] {
        PFX_EMPTY,
        PFX_DOLLAR,
        PFX_GOOD,
        PFX_BAD
    } nrp_prefix_t;

    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [DIG_W-1:0]   digits;
        logic               point;
        logic               stop;
    } nrp_num_t;

    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [DIG_W-1:0]   digits;
        logic               neg;
    } nrp_coord_t;

    typedef struct packed {
        logic       fix;
        nrp_coord_t lat;
        nrp_coord_t lon;
    } nrp_rec_t;

    function automatic logic [23:0] pow10(input logic [DIG_W-1:0] k);
        logic [23:0] p;
        case (k)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

>>> hdl/nmea_rmc_position_parser.sv
// NMEA RMC position parser.
//
// Input channel (rx_valid / rx_stall / rx_byte): one request per received
// character. A byte is taken at a rising edge with rx_valid high and rx_stall
// low. The scanner handles one byte every cycle while rx_stall is low;
// rx_stall rises only while the four-entry line queue is full.
//
// Result channel (res_valid / res_stall): one request per newline that closes
// a "$G..." or "$B..." line containing "RMC", carrying fix_valid and the held
// latitude_e7 / longitude_e7 (degrees times 1e7, south and west negative).
// From the newline to res_valid a line passes the queue write, six converter
// stages (divide by 100, whole minutes, fraction minutes, scale, divide by 60
// estimate, correction and saturation) and the output register. While
// res_stall is low the converter takes a new line every cycle.
//
// While res_valid and res_stall are both high the output register holds its
// request, the converter pipeline freezes and the queue fills; once full,
// rx_stall rises. Reset clears the line state, the queue and the held
// coordinates to zero; no clearing pass is needed.
module nmea_rmc_position_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rx_valid,
    output logic                                rx_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic                                fix_valid,
    output logic signed [nrp_pkg::COORD_W-1:0]  latitude_e7,
    output logic signed [nrp_pkg::COORD_W-1:0]  longitude_e7
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    nrp_pkg::nrp_rec_t rec_in;
    nrp_pkg::nrp_rec_t rec_head;

    // Hold input only when there is no room for a finished line
    assign rx_stall = q_full;
    assign accept   = rx_valid && !rx_stall;

    nrp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .push    (push),
        .rec     (rec_in)
    );

    nrp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (rec_in),
        .pop   (pop),
        .rdata (rec_head),
        .empty (q_empty),
        .full  (q_full)
    );

    nrp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (rec_head),
        .empty        (q_empty),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .fix_valid    (fix_valid),
        .latitude_e7  (latitude_e7),
        .longitude_e7 (longitude_e7)
    );

endmodule

>>> hdl/nrp_front.sv
module nrp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    output logic            push,
    output nrp_pkg::nrp_rec_t rec
);

    logic [nrp_pkg::LEN_W-1:0]   len_reg, len_next;
    nrp_pkg::nrp_prefix_t        prefix_reg, prefix_next;
    logic [1:0]                  rmc_prog_reg, rmc_prog_next;
    logic                        rmc_seen_reg, rmc_seen_next;
    logic [nrp_pkg::FIELD_W-1:0] field_reg, field_next;
    logic                        first_reg, first_next;
    logic [7:0]                  status_reg, status_next;
    logic [7:0]                  ns_reg, ns_next;
    logic [7:0]                  ew_reg, ew_next;
    nrp_pkg::nrp_num_t           lat_reg, lat_next;
    nrp_pkg::nrp_num_t           lon_reg, lon_next;

    // One character into a number field: digits, one point, anything else stops it
    function automatic nrp_pkg::nrp_num_t num_step(input nrp_pkg::nrp_num_t n,
                                                   input logic [7:0] c);
        nrp_pkg::nrp_num_t                r;
        logic [3:0]                       d;
        logic [nrp_pkg::WHOLE_W+3:0]      w;
        logic [nrp_pkg::FRAC_W+3:0]       f;
        r = n;
        d = c[3:0];
        w = (nrp_pkg::WHOLE_W+4)'(n.whole) * (nrp_pkg::WHOLE_W+4)'(10)
            + (nrp_pkg::WHOLE_W+4)'(d);
        f = (nrp_pkg::FRAC_W+4)'(n.frac) * (nrp_pkg::FRAC_W+4)'(10)
            + (nrp_pkg::FRAC_W+4)'(d);
        if (!n.stop) begin
            if (c >= nrp_pkg::CH_ZERO && c <= nrp_pkg::CH_NINE) begin
                if (!n.point) begin
                    if (w > (nrp_pkg::WHOLE_W+4)'(nrp_pkg::WHOLE_MAX))
                        r.whole = nrp_pkg::WHOLE_W'(nrp_pkg::WHOLE_MAX);
                    else
                        r.whole = w[nrp_pkg::WHOLE_W-1:0];
                end
                else if (n.digits < nrp_pkg::DIG_W'(nrp_pkg::MINUTE_FRACTION_DIGITS)) begin
                    r.frac   = f[nrp_pkg::FRAC_W-1:0];
                    r.digits = n.digits + 1'b1;
                end
            end
            else if (c == nrp_pkg::CH_POINT && !n.point) begin
                r.point = 1'b1;
            end
            else begin
                r.stop = 1'b1;
            end
        end
        return r;
    endfunction

    always_comb begin
        len_next      = len_reg;
        prefix_next   = prefix_reg;
        rmc_prog_next = rmc_prog_reg;
        rmc_seen_next = rmc_seen_reg;
        field_next    = field_reg;
        first_next    = first_reg;
        status_next   = status_reg;
        ns_next       = ns_reg;
        ew_next       = ew_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        push          = 1'b0;

        if (accept) begin
            if (rx_byte == nrp_pkg::CH_NL) begin
                push          = (prefix_reg == nrp_pkg::PFX_GOOD) && rmc_seen_reg;
                len_next      = '0;
                prefix_next   = nrp_pkg::PFX_EMPTY;
                rmc_prog_next = 2'd0;
                rmc_seen_next = 1'b0;
                field_next    = '0;
                first_next    = 1'b1;
                status_next   = nrp_pkg::CH_V;
                ns_next       = nrp_pkg::CH_N;
                ew_next       = nrp_pkg::CH_E;
                lat_next      = '0;
                lon_next      = '0;
            end
            else if (rx_byte != nrp_pkg::CH_CR
                     && len_reg < nrp_pkg::LEN_W'(nrp_pkg::LINE_LIMIT)) begin
                if (len_reg == '0)
                    prefix_next = (rx_byte == nrp_pkg::CH_DOLLAR) ? nrp_pkg::PFX_DOLLAR
                                                                 : nrp_pkg::PFX_BAD;
                else if (len_reg == nrp_pkg::LEN_W'(1))
                    prefix_next = (prefix_reg == nrp_pkg::PFX_DOLLAR
                                   && (rx_byte == nrp_pkg::CH_G || rx_byte == nrp_pkg::CH_B))
                                  ? nrp_pkg::PFX_GOOD : nrp_pkg::PFX_BAD;
                len_next = len_reg + 1'b1;

                if (rmc_prog_reg == 2'd2 && rx_byte == nrp_pkg::CH_C) begin
                    rmc_seen_next = 1'b1;
                    rmc_prog_next = 2'd0;
                end
                else if (rmc_prog_reg == 2'd1 && rx_byte == nrp_pkg::CH_M) begin
                    rmc_prog_next = 2'd2;
                end
                else begin
                    rmc_prog_next = (rx_byte == nrp_pkg::CH_R) ? 2'd1 : 2'd0;
                end

                if (rx_byte == nrp_pkg::CH_COMMA) begin
                    if (field_reg != nrp_pkg::FIELD_W'(nrp_pkg::FIELD_MAX))
                        field_next = field_reg + 1'b1;
                    first_next = 1'b1;
                end
                else begin
                    if (first_reg) begin
                        if (field_reg == nrp_pkg::FLD_STATUS)
                            status_next = rx_byte;
                        else if (field_reg == nrp_pkg::FLD_NS)
                            ns_next = rx_byte;
                        else if (field_reg == nrp_pkg::FLD_EW)
                            ew_next = rx_byte;
                    end
                    first_next = 1'b0;
                    if (field_reg == nrp_pkg::FLD_LAT)
                        lat_next = num_step(lat_reg, rx_byte);
                    else if (field_reg == nrp_pkg::FLD_LON)
                        lon_next = num_step(lon_reg, rx_byte);
                end
            end
        end
    end

    always_comb begin
        rec.fix        = (status_reg == nrp_pkg::CH_A);
        rec.lat.whole  = lat_reg.whole;
        rec.lat.frac   = lat_reg.frac;
        rec.lat.digits = lat_reg.digits;
        rec.lat.neg    = (ns_reg == nrp_pkg::CH_S);
        rec.lon.whole  = lon_reg.whole;
        rec.lon.frac   = lon_reg.frac;
        rec.lon.digits = lon_reg.digits;
        rec.lon.neg    = (ew_reg == nrp_pkg::CH_W);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            len_reg      <= '0;
            prefix_reg   <= nrp_pkg::PFX_EMPTY;
            rmc_prog_reg <= 2'd0;
            rmc_seen_reg <= 1'b0;
            field_reg    <= '0;
            first_reg    <= 1'b1;
            status_reg   <= nrp_pkg::CH_V;
            ns_reg       <= nrp_pkg::CH_N;
            ew_reg       <= nrp_pkg::CH_E;
            lat_reg      <= '0;
            lon_reg      <= '0;
        end
        else begin
            len_reg      <= len_next;
            prefix_reg   <= prefix_next;
            rmc_prog_reg <= rmc_prog_next;
            rmc_seen_reg <= rmc_seen_next;
            field_reg    <= field_next;
            first_reg    <= first_next;
            status_reg   <= status_next;
            ns_reg       <= ns_next;
            ew_reg       <= ew_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
        end
    end

endmodule

>>> hdl/nrp_queue.sv
module nrp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nrp_pkg::nrp_rec_t wdata,
    input  logic              pop,
    output nrp_pkg::nrp_rec_t rdata,
    output logic              empty,
    output logic              full
);

    nrp_pkg::nrp_rec_t                mem_reg [nrp_pkg::QUEUE_DEPTH];
    logic [nrp_pkg::QPTR_W-1:0]       wr_reg, wr_next;
    logic [nrp_pkg::QPTR_W-1:0]       rd_reg, rd_next;
    logic [nrp_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == nrp_pkg::QCNT_W'(nrp_pkg::QUEUE_DEPTH));
    assign rdata = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + nrp_pkg::QCNT_W'(push) - nrp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk) begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/nrp_conv.sv
module nrp_conv (
    input  logic                                clk,
    input  logic                                adv,
    input  nrp_pkg::nrp_coord_t                 coord,
    output logic signed [nrp_pkg::COORD_W-1:0]  result
);

    // Stage 1: integer degrees by reciprocal multiply
    logic                          s1_sat_reg, s1_neg_reg;
    logic [nrp_pkg::W15_W-1:0]     s1_w_reg;
    logic [7:0]                    s1_q_reg;
    logic [nrp_pkg::FRAC_W-1:0]    s1_frac_reg;
    logic [nrp_pkg::DIG_W-1:0]     s1_k_reg;
    // Stage 2: whole minutes and degrees scaled by 1e7
    logic                          s2_sat_reg, s2_neg_reg;
    logic [nrp_pkg::DEG_W-1:0]     s2_deg_reg;
    logic [6:0]                    s2_rem_reg;
    logic [nrp_pkg::FRAC_W-1:0]    s2_frac_reg;
    logic [nrp_pkg::DIG_W-1:0]     s2_k_reg;
    // Stage 3: minutes with kept fraction digits
    logic                          s3_sat_reg, s3_neg_reg;
    logic [nrp_pkg::DEG_W-1:0]     s3_deg_reg;
    logic [nrp_pkg::MIN_W-1:0]     s3_min_reg;
    logic [nrp_pkg::DIG_W-1:0]     s3_k_reg;
    // Stage 4: minutes scaled up to 1e7 units
    logic                          s4_sat_reg, s4_neg_reg;
    logic [nrp_pkg::DEG_W-1:0]     s4_deg_reg;
    logic [nrp_pkg::SC_W-1:0]      s4_sc_reg;
    // Stage 5: divide by 60 estimate
    logic                          s5_sat_reg, s5_neg_reg;
    logic [nrp_pkg::DEG_W-1:0]     s5_deg_reg;
    logic [nrp_pkg::Y_W-1:0]       s5_y_reg;
    logic [nrp_pkg::Q_W-1:0]       s5_q_reg;
    // Stage 6: corrected, saturated, signed
    logic signed [nrp_pkg::COORD_W-1:0] s6_res_reg;

    logic [27:0]                   q_prod;
    logic [nrp_pkg::W15_W-1:0]     rem_wide;
    logic [56:0]                   div_prod;
    logic [nrp_pkg::Y_W-1:0]       div_rem;
    logic [nrp_pkg::Q_W-1:0]       min_part;
    logic [nrp_pkg::COORD_W-1:0]   total;
    logic [nrp_pkg::COORD_W-1:0]   mag;

    always_comb begin
        q_prod   = 28'(coord.whole[nrp_pkg::W15_W-1:0]) * 28'(nrp_pkg::DIV100_MUL);
        rem_wide = s1_w_reg - nrp_pkg::W15_W'(nrp_pkg::W15_W'(s1_q_reg)
                                               * nrp_pkg::W15_W'(100));
        div_prod = 57'(s4_sc_reg[nrp_pkg::SC_W-1:2]) * 57'(nrp_pkg::RECIP15);
        div_rem  = s5_y_reg - nrp_pkg::Y_W'(32'(s5_q_reg) * 32'd15);
        // estimate is at most one short of the true quotient
        min_part = (div_rem >= nrp_pkg::Y_W'(15)) ? s5_q_reg + 1'b1 : s5_q_reg;
        total    = nrp_pkg::COORD_W'(s5_deg_reg) + nrp_pkg::COORD_W'(min_part);
        mag      = (s5_sat_reg || total > nrp_pkg::COORD_MAX) ? nrp_pkg::COORD_MAX : total;
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            s1_sat_reg  <= (coord.whole >= nrp_pkg::SAT_WHOLE);
            s1_neg_reg  <= coord.neg;
            s1_w_reg    <= coord.whole[nrp_pkg::W15_W-1:0];
            s1_q_reg    <= q_prod[nrp_pkg::DIV100_SHR+7:nrp_pkg::DIV100_SHR];
            s1_frac_reg <= coord.frac;
            s1_k_reg    <= coord.digits;

            s2_sat_reg  <= s1_sat_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_deg_reg  <= nrp_pkg::DEG_W'(nrp_pkg::DEG_W'(s1_q_reg)
                                           * nrp_pkg::DEG_W'(nrp_pkg::E7));
            s2_rem_reg  <= rem_wide[6:0];
            s2_frac_reg <= s1_frac_reg;
            s2_k_reg    <= s1_k_reg;

            s3_sat_reg  <= s2_sat_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_deg_reg  <= s2_deg_reg;
            s3_min_reg  <= nrp_pkg::MIN_W'(32'(s2_rem_reg) * 32'(nrp_pkg::pow10(s2_k_reg))
                                           + 32'(s2_frac_reg));
            s3_k_reg    <= s2_k_reg;

            s4_sat_reg  <= s3_sat_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_deg_reg  <= s3_deg_reg;
            s4_sc_reg   <= nrp_pkg::SC_W'(48'(s3_min_reg)
                                          * 48'(nrp_pkg::pow10(3'd7 - s3_k_reg)));

            s5_sat_reg  <= s4_sat_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_deg_reg  <= s4_deg_reg;
            s5_y_reg    <= s4_sc_reg[nrp_pkg::SC_W-1:2];
            s5_q_reg    <= div_prod[32+nrp_pkg::Q_W-1:32];

            s6_res_reg  <= s5_neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign result = s6_res_reg;

endmodule

>>> hdl/nrp_back.sv
module nrp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nrp_pkg::nrp_rec_t                   head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic                                fix_valid,
    output logic signed [nrp_pkg::COORD_W-1:0]  latitude_e7,
    output logic signed [nrp_pkg::COORD_W-1:0]  longitude_e7
);

    logic                                 adv;
    logic [nrp_pkg::CONV_STAGES-1:0]      vld_reg, vld_next;
    logic [nrp_pkg::CONV_STAGES-1:0]      fix_reg, fix_next;
    logic signed [nrp_pkg::COORD_W-1:0]   lat_conv, lon_conv;
    logic signed [nrp_pkg::COORD_W-1:0]   held_lat_reg, held_lat_next;
    logic signed [nrp_pkg::COORD_W-1:0]   held_lon_reg, held_lon_next;
    logic                                 out_vld_reg, out_vld_next;
    logic                                 out_fix_reg;
    logic signed [nrp_pkg::COORD_W-1:0]   out_lat_reg, out_lon_reg;
    logic                                 last;

    // Advance the whole pipeline while the output register can take a result
    assign adv  = !out_vld_reg || !res_stall;
    assign pop  = adv && !empty;
    assign last = vld_reg[nrp_pkg::CONV_STAGES-1];

    nrp_conv u_lat (
        .clk    (clk),
        .adv    (adv),
        .coord  (head.lat),
        .result (lat_conv)
    );

    nrp_conv u_lon (
        .clk    (clk),
        .adv    (adv),
        .coord  (head.lon),
        .result (lon_conv)
    );

    always_comb begin
        vld_next      = vld_reg;
        fix_next      = fix_reg;
        held_lat_next = held_lat_reg;
        held_lon_next = held_lon_reg;
        out_vld_next  = out_vld_reg;
        if (adv) begin
            vld_next     = {vld_reg[nrp_pkg::CONV_STAGES-2:0], !empty};
            fix_next     = {fix_reg[nrp_pkg::CONV_STAGES-2:0], head.fix};
            out_vld_next = last;
            if (last && fix_reg[nrp_pkg::CONV_STAGES-1]) begin
                held_lat_next = lat_conv;
                held_lon_next = lon_conv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg      <= '0;
            held_lat_reg <= '0;
            held_lon_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else begin
            vld_reg      <= vld_next;
            held_lat_reg <= held_lat_next;
            held_lon_reg <= held_lon_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk) begin
        fix_reg <= fix_next;
        if (adv && last) begin
            out_fix_reg <= fix_reg[nrp_pkg::CONV_STAGES-1];
            out_lat_reg <= held_lat_next;
            out_lon_reg <= held_lon_next;
        end
    end

    assign res_valid    = out_vld_reg;
    assign fix_valid    = out_fix_reg;
    assign latitude_e7  = out_lat_reg;
    assign longitude_e7 = out_lon_reg;

endmodule

>>> hdl/nrp_checker.sv
module nrp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rx_valid,
    input  logic                                rx_stall,
    input  logic [7:0]                          rx_byte,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  logic                                fix_valid,
    input  logic signed [nrp_pkg::COORD_W-1:0]  latitude_e7,
    input  logic signed [nrp_pkg::COORD_W-1:0]  longitude_e7
);

    logic signed [nrp_pkg::COORD_W-1:0] last_lat_reg;
    logic signed [nrp_pkg::COORD_W-1:0] last_lon_reg;

    // Track the coordinates of the last delivered request
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            last_lat_reg <= '0;
            last_lon_reg <= '0;
        end
        else if (res_valid && !res_stall) begin
            last_lat_reg <= latitude_e7;
            last_lon_reg <= longitude_e7;
        end
    end

    a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_stall |=> rx_valid && $stable(rx_byte))
        else $error("input request changed while stalled");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(fix_valid)
            && $stable(latitude_e7) && $stable(longitude_e7))
        else $error("result changed while stalled");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> latitude_e7 <= $signed(nrp_pkg::COORD_MAX)
            && latitude_e7 >= -$signed(nrp_pkg::COORD_MAX))
        else $error("latitude out of range");

    a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> longitude_e7 <= $signed(nrp_pkg::COORD_MAX)
            && longitude_e7 >= -$signed(nrp_pkg::COORD_MAX))
        else $error("longitude out of range");

    a_nofix_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !fix_valid |-> latitude_e7 == last_lat_reg
            && longitude_e7 == last_lon_reg)
        else $error("result without fix changed held coordinates");

endmodule

bind nmea_rmc_position_parser nrp_checker u_nrp_checker (.*);

>>> tb/tb_top.sv
module tb_top;

    import nrp_pkg::*;

    // One position report as it leaves the block
    typedef struct packed {
        logic                       fix;
        logic signed [COORD_W-1:0]  lat;
        logic signed [COORD_W-1:0]  lon;
    } fix_report_t;

    // Text of one ddmm.mmmm / dddmm.mmmm field as read so far
    typedef struct {
        int unsigned whole;
        int unsigned frac;
        int unsigned digits;
        bit          point;
        bit          stop;
    } coord_text_t;

    // Tracks the line being received, predicts the report that each newline
    // causes, and compares reports from the block against that prediction.
    class rmc_fix_scoreboard;
        fix_report_t        pending_fixes[$];
        int                 errors;
        int                 reports_queued;
        int                 reports_checked;
        int                 reports_with_fix;

        int unsigned        line_len;
        nrp_prefix_t        prefix_state;
        int unsigned        rmc_match;
        bit                 rmc_found;
        int unsigned        field_idx;
        bit                 at_field_start;
        logic [7:0]         status_ch;
        logic [7:0]         ns_ch;
        logic [7:0]         ew_ch;
        coord_text_t        lat_text;
        coord_text_t        lon_text;
        logic [COORD_W-1:0] held_lat;
        logic [COORD_W-1:0] held_lon;

        function new();
            errors           = 0;
            reports_queued   = 0;
            reports_checked  = 0;
            reports_with_fix = 0;
            held_lat         = '0;
            held_lon         = '0;
            clear_line();
        endfunction

        function void clear_line();
            line_len       = 0;
            prefix_state   = PFX_EMPTY;
            rmc_match      = 0;
            rmc_found      = 0;
            field_idx      = 0;
            at_field_start = 1;
            status_ch      = CH_V;
            ns_ch          = CH_N;
            ew_ch          = CH_E;
            lat_text       = '{default: 0};
            lon_text       = '{default: 0};
        endfunction

        // Advance a number field by one character; stop on anything not a
        // digit or a first point.
        function coord_text_t number_step(coord_text_t n, logic [7:0] c);
            coord_text_t r;
            r = n;
            if (r.stop)
                return r;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (!r.point) begin
                    r.whole = r.whole * 10 + (c - CH_ZERO);
                    if (r.whole > WHOLE_MAX)
                        r.whole = WHOLE_MAX;
                end
                else if (r.digits < MINUTE_FRACTION_DIGITS) begin
                    r.frac   = r.frac * 10 + (c - CH_ZERO);
                    r.digits = r.digits + 1;
                end
            end
            else if (c == CH_POINT && !r.point)
                r.point = 1;
            else
                r.stop = 1;
            return r;
        endfunction

        // Degrees and minutes text to degrees times 1e7, truncated and saturated
        function logic [COORD_W-1:0] degrees_e7(coord_text_t n, bit neg);
            longint unsigned scale;
            longint unsigned minutes;
            longint unsigned v;
            scale = 1;
            for (int i = 0; i < n.digits; i++)
                scale = scale * 10;
            minutes = 64'(n.whole % 100) * scale + 64'(n.frac);
            v = 64'(n.whole / 100) * 64'(E7) + (minutes * 64'(E7)) / (64'd60 * scale);
            if (v > 64'(COORD_MAX))
                v = 64'(COORD_MAX);
            return neg ? -v[COORD_W-1:0] : v[COORD_W-1:0];
        endfunction

        // Note one accepted character request
        function void take_char(logic [7:0] c);
            fix_report_t r;
            if (c == CH_NL) begin
                if (prefix_state == PFX_GOOD && rmc_found) begin
                    r.fix = (status_ch == CH_A);
                    if (r.fix) begin
                        held_lat = degrees_e7(lat_text, ns_ch == CH_S);
                        held_lon = degrees_e7(lon_text, ew_ch == CH_W);
                    end
                    r.lat = held_lat;
                    r.lon = held_lon;
                    pending_fixes.push_back(r);
                    reports_queued++;
                end
                clear_line();
                return;
            end
            if (c == CH_CR || line_len >= LINE_LIMIT)
                return;

            if (line_len == 0) begin
                if (c == CH_DOLLAR)
                    prefix_state = PFX_DOLLAR;
                else
                    prefix_state = PFX_BAD;
            end
            else if (line_len == 1) begin
                if (prefix_state == PFX_DOLLAR && (c == CH_G || c == CH_B))
                    prefix_state = PFX_GOOD;
                else
                    prefix_state = PFX_BAD;
            end
            line_len++;

            if (rmc_match == 2 && c == CH_C) begin
                rmc_found = 1;
                rmc_match = 0;
            end
            else if (rmc_match == 1 && c == CH_M)
                rmc_match = 2;
            else
                rmc_match = (c == CH_R) ? 1 : 0;

            if (c == CH_COMMA) begin
                if (field_idx < FIELD_MAX)
                    field_idx++;
                at_field_start = 1;
                return;
            end
            if (at_field_start) begin
                if (field_idx == FLD_STATUS)
                    status_ch = c;
                else if (field_idx == FLD_NS)
                    ns_ch = c;
                else if (field_idx == FLD_EW)
                    ew_ch = c;
            end
            at_field_start = 0;
            if (field_idx == FLD_LAT)
                lat_text = number_step(lat_text, c);
            else if (field_idx == FLD_LON)
                lon_text = number_step(lon_text, c);
        endfunction

        // Compare one accepted report with the oldest prediction
        function void check_fix(logic fix, logic signed [COORD_W-1:0] lat,
                                logic signed [COORD_W-1:0] lon);
            fix_report_t want;
            if (pending_fixes.size() == 0) begin
                errors++;
                $display("%0t: report with no sentence waiting: fix_valid=%0d lat=%0d lon=%0d",
                         $time, fix, lat, lon);
                return;
            end
            want = pending_fixes.pop_front();
            reports_checked++;
            if (want.fix)
                reports_with_fix++;
            if (fix !== want.fix) begin
                errors++;
                $display("%0t: fix_valid expected %0d got %0d", $time, want.fix, fix);
            end
            if (lat !== want.lat) begin
                errors++;
                $display("%0t: latitude_e7 expected %0d got %0d", $time, want.lat, lat);
            end
            if (lon !== want.lon) begin
                errors++;
                $display("%0t: longitude_e7 expected %0d got %0d", $time, want.lon, lon);
            end
        endfunction
    endclass

    // Clock and block ports; every input starts at a known value
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       rx_valid  = 1'b0;
    logic                       rx_stall;
    logic [7:0]                 rx_byte   = 8'h00;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    logic                       fix_valid;
    logic signed [COORD_W-1:0]  latitude_e7;
    logic signed [COORD_W-1:0]  longitude_e7;

    rmc_fix_scoreboard sb = new();

    // Idling odds in percent per cycle, changed between phases
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int chars_sent = 0;
    int lines_sent = 0;
    int drains     = 0;

    // Bytes of the line under construction
    logic [7:0] sentence_bytes[$];

    nmea_rmc_position_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .fix_valid    (fix_valid),
        .latitude_e7  (latitude_e7),
        .longitude_e7 (longitude_e7)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake
    initial
    begin
        #(12 * 400000);
        $display("nmea_rmc_position_parser verification failed");
        $finish;
    end

    // Result side: check every accepted report request, then pick the stall
    // for the next cycle. Values read here are those from before the edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                sb.check_fix(fix_valid, latitude_e7, longitude_e7);
            res_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Offer one character request; idle first at the sender's odds, then hold
    // the byte until a rising edge sees rx_stall low. Returns in the time step
    // of the accepting edge with rx_valid still high.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        sb.take_char(c);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (sentence_bytes[i])
            send_char(sentence_bytes[i]);
        sentence_bytes.delete();
        lines_sent++;
    endtask

    // Hold off the sender until every predicted report has come back
    task automatic drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_fixes.size() != 0)
            @(posedge clk);
        drains++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            sentence_bytes.push_back(s[i]);
    endtask

    task automatic put_repeat(input logic [7:0] c, input int n);
        repeat (n) sentence_bytes.push_back(c);
    endtask

    task automatic put_digits(input int n);
        repeat (n) sentence_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    endtask

    task automatic put_padding(input int n);
        repeat (n) sentence_bytes.push_back(8'($urandom_range(32, 126)));
    endtask

    // Number field; now and then a stray character cuts the number short
    task automatic put_number(input int whole_n, input int frac_n, input bit with_point);
        int pick;
        put_digits(whole_n);
        if (with_point)
            sentence_bytes.push_back(CH_POINT);
        put_digits(frac_n);
        if ($urandom_range(14) == 0)
        begin
            pick = $urandom_range(2);
            if (pick == 0)
                sentence_bytes.push_back(CH_POINT);
            else if (pick == 1)
                sentence_bytes.push_back(8'($urandom_range(65, 90)));
            else
                sentence_bytes.push_back(8'($urandom_range(0, 255)));
            put_digits($urandom_range(0, 3));
        end
    endtask

    // Mostly well formed RMC sentence with random content
    task automatic build_sentence();
        int pick;
        put_text("$");
        pick = $urandom_range(9);
        if (pick < 5)
            sentence_bytes.push_back(CH_G);
        else if (pick < 9)
            sentence_bytes.push_back(CH_B);
        else
            sentence_bytes.push_back(8'($urandom_range(65, 90)));
        sentence_bytes.push_back(8'($urandom_range(65, 90)));
        put_text(($urandom_range(19) == 0) ? "RMX" : "RMC");
        sentence_bytes.push_back(CH_COMMA);
        // time field, sometimes long enough to push the position off the line
        if ($urandom_range(19) == 0)
            put_padding($urandom_range(90, 140));
        else
        begin
            put_digits(6);
            put_text(".");
            put_digits(2);
        end
        sentence_bytes.push_back(CH_COMMA);
        pick = $urandom_range(9);
        if (pick < 6)
            sentence_bytes.push_back(CH_A);
        else if (pick < 8)
            sentence_bytes.push_back(CH_V);
        else if (pick == 9)
            sentence_bytes.push_back(8'($urandom_range(0, 255)));
        sentence_bytes.push_back(CH_COMMA);
        if ($urandom_range(9) < 8)
            put_number(4, $urandom_range(0, 8), $urandom_range(9) != 0);
        else
            put_number($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(9) != 0);
        sentence_bytes.push_back(CH_COMMA);
        pick = $urandom_range(4);
        if (pick < 2)
            sentence_bytes.push_back(CH_N);
        else if (pick < 4)
            sentence_bytes.push_back(CH_S);
        sentence_bytes.push_back(CH_COMMA);
        if ($urandom_range(9) < 8)
            put_number(5, $urandom_range(0, 8), $urandom_range(9) != 0);
        else
            put_number($urandom_range(0, 9), $urandom_range(0, 8), $urandom_range(9) != 0);
        sentence_bytes.push_back(CH_COMMA);
        pick = $urandom_range(4);
        if (pick < 2)
            sentence_bytes.push_back(CH_E);
        else if (pick < 4)
            sentence_bytes.push_back(CH_W);
        repeat ($urandom_range(0, 5))
        begin
            sentence_bytes.push_back(CH_COMMA);
            put_digits($urandom_range(0, 4));
        end
        if ($urandom_range(19) == 0)
            put_padding($urandom_range(100, 150));
        if ($urandom_range(9) < 7)
            sentence_bytes.push_back(CH_CR);
        sentence_bytes.push_back(CH_NL);
    endtask

    // Sentence with one byte overwritten or the tail cut off
    task automatic build_broken();
        int pos;
        build_sentence();
        pos = $urandom_range(0, sentence_bytes.size() - 2);
        if ($urandom_range(1) == 0)
            sentence_bytes[pos] = 8'($urandom_range(0, 255));
        else
        begin
            while (sentence_bytes.size() > pos)
                void'(sentence_bytes.pop_back());
            sentence_bytes.push_back(CH_NL);
        end
    endtask

    // Random bytes of every value, sometimes behind a good prefix
    task automatic build_noise();
        if ($urandom_range(3) == 0)
            put_text("$G");
        repeat ($urandom_range(0, 40)) sentence_bytes.push_back(8'($urandom_range(0, 255)));
        sentence_bytes.push_back(CH_NL);
    endtask

    task automatic set_phase(input int phase);
        case (phase)
            0:
            begin
                sender_idle_pct    = 13;
                receiver_stall_pct = 81;
            end
            1:
            begin
                sender_idle_pct    = 81;
                receiver_stall_pct = 13;
            end
            default:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    // Stimulus
    initial
    begin
        int phase;
        int pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        phase = 0;
        set_phase(phase);

        // Directed lines: ordinary fix with CR, south and west with extra
        // minute digits, void status, empty fields, saturation, bad number
        // text, first letters only, overlapping RMC, wrong or short prefixes.
        put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
        send_line();
        put_text("$BDRMC,,A,3345.12345678,S,15112.5,W\n");
        send_line();
        put_text("$GNRMC,,V,1234.5,N,1234.5,E\n");
        send_line();
        put_text("$GPRMC,,A,,,,\n");
        send_line();
        put_text("$GPRMC,,A,9999999.99,N,131072999,W\n");
        send_line();
        put_text("$GPRMC,,A,12a34.5,N,1.2.3,E\n");
        send_line();
        put_text("$GPRMC,,A,.5,S,0.,W\n");
        send_line();
        put_text("$GPRMC,,AV,4807.038,Sx,01131.000,Wy,,,,,,,,,\n");
        send_line();
        put_text("$GRMRMC,,A,0130.0,N,00030.0,E\n");
        send_line();
        put_text("$GRMMC,,A,1,N,1,E\n");
        send_line();
        put_text("$GPGGA,,A,1,N,1,E\n");
        send_line();
        put_text("$XPRMC,,A,1,N,1,E\n");
        send_line();
        put_text("G$RMC\n");
        send_line();
        put_text("$\n");
        send_line();
        put_text("\n");
        send_line();
        put_text("$G\n");
        send_line();
        put_text("\r\r\n");
        send_line();
        // zero byte and all-ones byte inside a field
        put_text("$GPRMC,");
        sentence_bytes.push_back(8'h00);
        sentence_bytes.push_back(8'hFF);
        put_text(",A,0000.00000,N,00000.0,E\n");
        send_line();
        // RMC only after the line limit: no report
        put_text("$GP");
        put_repeat("x", 130);
        put_text("RMC,,A,1,N,1,E\n");
        send_line();
        // hemisphere past the line limit stays at its default
        put_text("$GPRMC,,A,1000.0,N,02000.0,");
        put_repeat("x", 100);
        put_text(",W\n");
        send_line();

        // Random part: mostly sentences, the rest broken lines and noise.
        // Switch idling phase after a drain so every expected report is out.
        while (chars_sent < 1850)
        begin
            if (phase < 2 && chars_sent >= (phase + 1) * 620)
            begin
                drain_results();
                phase++;
                set_phase(phase);
            end
            pick = $urandom_range(99);
            if (pick < 70)
                build_sentence();
            else if (pick < 85)
                build_broken();
            else
                build_noise();
            send_line();
        end

        // Drop valid, wait for the last reports, then give the block time to
        // show any report that should not come.
        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d characters on %0d lines through three idling phases, %0d drains.",
                 chars_sent, lines_sent, drains);
        $display("Checked %0d position reports, %0d of them with a fix.",
                 sb.reports_checked, sb.reports_with_fix);
        if (sb.errors == 0)
            $display("nmea_rmc_position_parser verification clean");
        else
            $display("nmea_rmc_position_parser verification failed");
        $finish;
    end

endmodule
